@@ src/ppmi_pkg.sv @@
`timescale 1ns / 1ps

package ppmi_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam int MODE_BITS     = 3;
    localparam int NOW_BITS      = 31;
    localparam int IO_COORD_BITS = 16;
    localparam int SPEED_BITS    = 15;
    localparam int DUR_BITS      = 31;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 31;
    localparam int UPC_BITS      = 5;

    localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(1);
    localparam logic [DUR_BITS-1:0]   DUR_RESET   = DUR_BITS'(1000);

    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_X   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_Y   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION  = 2'd3;

    localparam logic MM_SPEED = 1'b0;
    localparam logic MM_TIME  = 1'b1;

    typedef enum logic [MODE_BITS-1:0] {
        CMD_TICK   = 3'd0,
        CMD_TARGET = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_PLACE  = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_EMIT,
        OP_LATCH,
        OP_SPEED,
        OP_ARRIVE,
        OP_ELAPSED,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_SNAP,
        OP_ORIGIN,
        OP_SET_TARGET,
        OP_PAUSE,
        OP_RESUME,
        OP_STOP,
        OP_PLACE
    } t_op;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_OUT_BUSY,
        C_NO_ITEM,
        C_DISPATCH,
        C_AT_GOAL,
        C_TIME_MODE,
        C_FINISHED,
        C_E_GT_D,
        C_D_ZERO,
        C_LOOP
    } t_cond;

    typedef logic [UPC_BITS-1:0] t_upc;

    localparam t_upc U_EMIT   = 5'd0;
    localparam t_upc U_IDLE   = 5'd1;
    localparam t_upc U_DISP   = 5'd2;
    localparam t_upc U_TICK   = 5'd3;
    localparam t_upc U_TSEL   = 5'd4;
    localparam t_upc U_SPEED  = 5'd5;
    localparam t_upc U_ARRIVE = 5'd6;
    localparam t_upc U_TIME   = 5'd7;
    localparam t_upc U_DINIT  = 5'd8;
    localparam t_upc U_DZERO  = 5'd9;
    localparam t_upc U_LOOP   = 5'd10;
    localparam t_upc U_DDONE  = 5'd11;
    localparam t_upc U_SNAP   = 5'd12;
    localparam t_upc U_ORIGIN = 5'd13;
    localparam t_upc U_TARGET = 5'd14;
    localparam t_upc U_PAUSE  = 5'd15;
    localparam t_upc U_RESUME = 5'd16;
    localparam t_upc U_STOP   = 5'd17;
    localparam t_upc U_PLACE  = 5'd18;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
        logic  cnt_ld;
        logic  cnt_dec;
    } t_uword;

    typedef struct packed {
        logic out_busy;
        logic at_goal;
        logic time_mode;
        logic finished;
        logic e_gt_d;
        logic d_zero;
        t_cmd cmd;
    } t_flags;

    function automatic t_uword ucode_rom(input t_upc addr);
        ucode_rom = '{OP_NOP, C_ALWAYS, U_IDLE, 1'b0, 1'b0};
        case (addr)
            U_EMIT:   ucode_rom = '{OP_EMIT,       C_OUT_BUSY,  U_EMIT,   1'b0, 1'b0};
            U_IDLE:   ucode_rom = '{OP_LATCH,      C_NO_ITEM,   U_IDLE,   1'b0, 1'b0};
            U_DISP:   ucode_rom = '{OP_NOP,        C_DISPATCH,  U_EMIT,   1'b0, 1'b0};
            U_TICK:   ucode_rom = '{OP_NOP,        C_AT_GOAL,   U_EMIT,   1'b0, 1'b0};
            U_TSEL:   ucode_rom = '{OP_NOP,        C_TIME_MODE, U_TIME,   1'b0, 1'b0};
            U_SPEED:  ucode_rom = '{OP_SPEED,      C_ALWAYS,    U_ARRIVE, 1'b0, 1'b0};
            U_ARRIVE: ucode_rom = '{OP_ARRIVE,     C_ALWAYS,    U_EMIT,   1'b0, 1'b0};
            U_TIME:   ucode_rom = '{OP_ELAPSED,    C_FINISHED,  U_EMIT,   1'b0, 1'b0};
            U_DINIT:  ucode_rom = '{OP_DIV_INIT,   C_E_GT_D,    U_SNAP,   1'b1, 1'b0};
            U_DZERO:  ucode_rom = '{OP_NOP,        C_D_ZERO,    U_ORIGIN, 1'b0, 1'b0};
            U_LOOP:   ucode_rom = '{OP_DIV_STEP,   C_LOOP,      U_LOOP,   1'b0, 1'b1};
            U_DDONE:  ucode_rom = '{OP_DIV_DONE,   C_ALWAYS,    U_ARRIVE, 1'b0, 1'b0};
            U_SNAP:   ucode_rom = '{OP_SNAP,       C_ALWAYS,    U_ARRIVE, 1'b0, 1'b0};
            U_ORIGIN: ucode_rom = '{OP_ORIGIN,     C_ALWAYS,    U_ARRIVE, 1'b0, 1'b0};
            U_TARGET: ucode_rom = '{OP_SET_TARGET, C_ALWAYS,    U_EMIT,   1'b0, 1'b0};
            U_PAUSE:  ucode_rom = '{OP_PAUSE,      C_ALWAYS,    U_EMIT,   1'b0, 1'b0};
            U_RESUME: ucode_rom = '{OP_RESUME,     C_ALWAYS,    U_EMIT,   1'b0, 1'b0};
            U_STOP:   ucode_rom = '{OP_STOP,       C_ALWAYS,    U_EMIT,   1'b0, 1'b0};
            U_PLACE:  ucode_rom = '{OP_PLACE,      C_ALWAYS,    U_EMIT,   1'b0, 1'b0};
            default:  ucode_rom = '{OP_NOP,        C_ALWAYS,    U_IDLE,   1'b0, 1'b0};
        endcase
    endfunction

    function automatic t_upc dispatch(input t_cmd cmd);
        case (cmd)
            CMD_TICK:   dispatch = U_TICK;
            CMD_TARGET: dispatch = U_TARGET;
            CMD_PAUSE:  dispatch = U_PAUSE;
            CMD_RESUME: dispatch = U_RESUME;
            CMD_STOP:   dispatch = U_STOP;
            CMD_PLACE:  dispatch = U_PLACE;
            default:    dispatch = U_EMIT;
        endcase
    endfunction

endpackage

@@ src/point_to_point_motion_interpolator.sv @@
`timescale 1ns / 1ps

// Moves a 2D point toward a target under a small microcoded sequencer. Items are
// taken one at a time. Place, set target, pause, resume and stop each run their
// own step before the result is emitted, and an unused mode goes straight to the
// output step. A tick at the goal, or a timed tick after the motion has finished,
// goes on to the output step; a fixed-speed tick takes a speed step; a fixed-time
// tick snaps to the target, returns to the origin with a zero duration, or else runs
// the interpolation loop, which feeds one bit of the axis distance per cycle through one
// multiply-divide lane per axis. A result waiting in the output register holds the
// block at its final step until taken.

module point_to_point_motion_interpolator
    import ppmi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic        [MODE_BITS-1:0]     i_mode,
    input  logic        [NOW_BITS-1:0]      i_now_ms,
    input  logic signed [IO_COORD_BITS-1:0] i_coord_x,
    input  logic signed [IO_COORD_BITS-1:0] i_coord_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [IO_COORD_BITS-1:0] o_pos_x,
    output logic signed [IO_COORD_BITS-1:0] o_pos_y,
    output logic                            o_at_target,
    output logic                            o_arrived,
    input  logic                            i_cfg_we,
    input  logic        [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_op    op;
    t_flags flags;
    logic   idle;
    logic   accept;

    assign o_stall = !idle;
    assign accept  = i_valid && idle;

    ppmi_useq #(
        .COORD_BITS(COORD_BITS)
    ) u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_flags  (flags),
        .o_op     (op),
        .o_idle   (idle)
    );

    ppmi_dp #(
        .COORD_BITS(COORD_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_now_ms    (i_now_ms),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_stall),
        .o_flags     (flags),
        .o_valid     (o_valid),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_at_target (o_at_target),
        .o_arrived   (o_arrived)
    );

endmodule

@@ src/ppmi_muldiv.sv @@
`timescale 1ns / 1ps

module ppmi_muldiv
    import ppmi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_init,
    input  logic                         i_step,
    input  logic signed [COORD_BITS-1:0] i_origin,
    input  logic signed [COORD_BITS-1:0] i_goal,
    input  logic        [DUR_BITS-1:0]   i_elapsed,
    input  logic        [DUR_BITS-1:0]   i_dur,
    output logic signed [COORD_BITS-1:0] o_value
);

    localparam int MW = COORD_BITS + 1;
    localparam int RW = DUR_BITS + 2;
    localparam int VW = COORD_BITS + 2;

    logic        [MW-1:0]         r_mag;
    logic                         r_neg;
    logic        [RW-1:0]         r_rem;
    logic        [MW-1:0]         r_q;
    logic signed [COORD_BITS-1:0] r_origin;

    logic signed [MW-1:0] diff;
    logic        [RW-1:0] rem2;
    logic        [RW-1:0] rem_next;
    logic        [1:0]    digit;
    logic signed [VW-1:0] qs;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] v_fix;
    logic                 rnz;

    // Each step feeds one bit of |goal - origin| into a running remainder, so the
    // quotient of elapsed * |delta| / duration is built without a wide product.
    always_comb begin
        diff = {i_goal[COORD_BITS-1], i_goal} - {i_origin[COORD_BITS-1], i_origin};
        rem2 = {r_rem[RW-2:0], 1'b0} + (r_mag[MW-1] ? RW'(i_elapsed) : RW'(0));
        if (rem2 >= {1'b0, i_dur, 1'b0}) begin
            rem_next = rem2 - {1'b0, i_dur, 1'b0};
            digit    = 2'd2;
        end else if (rem2 >= RW'(i_dur)) begin
            rem_next = rem2 - RW'(i_dur);
            digit    = 2'd1;
        end else begin
            rem_next = rem2;
            digit    = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_mag    <= diff[MW-1] ? MW'(-diff) : MW'(diff);
            r_neg    <= diff[MW-1];
            r_rem    <= '0;
            r_q      <= '0;
            r_origin <= i_origin;
        end else if (i_step) begin
            r_mag <= {r_mag[MW-2:0], 1'b0};
            r_rem <= rem_next;
            r_q   <= {r_q[MW-2:0], 1'b0} + MW'(digit);
        end
    end

    always_comb begin
        qs    = r_neg ? -signed'({1'b0, r_q}) : signed'({1'b0, r_q});
        v     = {r_origin[COORD_BITS-1], r_origin[COORD_BITS-1], r_origin} + qs;
        rnz   = |r_rem;
        v_fix = v;
        if (rnz && !r_neg && v[VW-1]) begin
            v_fix = v + VW'(1);
        end else if (rnz && r_neg && !v[VW-1] && (|v)) begin
            v_fix = v - VW'(1);
        end
    end

    assign o_value = v_fix[COORD_BITS-1:0];

endmodule

@@ src/ppmi_dp.sv @@
`timescale 1ns / 1ps

module ppmi_dp
    import ppmi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_op                             i_op,
    input  logic                            i_accept,
    input  logic        [MODE_BITS-1:0]     i_mode,
    input  logic        [NOW_BITS-1:0]      i_now_ms,
    input  logic signed [IO_COORD_BITS-1:0] i_coord_x,
    input  logic signed [IO_COORD_BITS-1:0] i_coord_y,
    input  logic                            i_cfg_we,
    input  logic        [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                            i_out_stall,
    output t_flags                          o_flags,
    output logic                            o_valid,
    output logic signed [IO_COORD_BITS-1:0] o_pos_x,
    output logic signed [IO_COORD_BITS-1:0] o_pos_y,
    output logic                            o_at_target,
    output logic                            o_arrived
);

    localparam int CB = COORD_BITS;
    localparam int TB = TIME_BITS;
    localparam int EW = (TB > DUR_BITS) ? TB : DUR_BITS;
    localparam int SW = ((CB > SPEED_BITS) ? CB : SPEED_BITS) + 2;

    logic                  r_move_mode;
    logic [SPEED_BITS-1:0] r_speed_x;
    logic [SPEED_BITS-1:0] r_speed_y;
    logic [DUR_BITS-1:0]   r_dur;

    t_cmd                 r_cmd;
    logic        [TB-1:0] r_now;
    logic signed [CB-1:0] r_cx;
    logic signed [CB-1:0] r_cy;

    logic signed [CB-1:0] r_px, n_px;
    logic signed [CB-1:0] r_py, n_py;
    logic signed [CB-1:0] r_gx, n_gx;
    logic signed [CB-1:0] r_gy, n_gy;
    logic signed [CB-1:0] r_ox, n_ox;
    logic signed [CB-1:0] r_oy, n_oy;
    logic        [TB-1:0] r_start, n_start;
    logic        [TB-1:0] r_sleep, n_sleep;
    logic                 r_finished, n_finished;
    logic        [TB-1:0] r_elapsed, n_elapsed;
    logic                 r_arrived, n_arrived;

    logic                            r_o_valid, n_o_valid;
    logic signed [IO_COORD_BITS-1:0] r_o_px, n_o_px;
    logic signed [IO_COORD_BITS-1:0] r_o_py, n_o_py;
    logic                            r_o_at, n_o_at;
    logic                            r_o_arr, n_o_arr;

    logic        [TB-1:0] diff_t;
    logic                 at_goal;
    logic                 out_busy;
    logic signed [CB-1:0] lane_x;
    logic signed [CB-1:0] lane_y;

    function automatic logic signed [CB-1:0] speed_axis(
        input logic signed [CB-1:0]   p,
        input logic signed [CB-1:0]   g,
        input logic [SPEED_BITS-1:0]  sp
    );
        logic signed [SW-1:0] dd;
        logic signed [SW-1:0] spw;
        logic signed [SW-1:0] res;
        dd  = SW'(g) - SW'(p);
        spw = SW'({1'b0, sp});
        if (dd > 0) begin
            res = (dd < spw) ? SW'(g) : SW'(p) + spw;
        end else begin
            res = (dd > -spw) ? SW'(g) : SW'(p) - spw;
        end
        speed_axis = res[CB-1:0];
    endfunction

    ppmi_muldiv #(
        .COORD_BITS(CB)
    ) u_lane_x (
        .i_clk     (i_clk),
        .i_init    (i_op == OP_DIV_INIT),
        .i_step    (i_op == OP_DIV_STEP),
        .i_origin  (r_ox),
        .i_goal    (r_gx),
        .i_elapsed (DUR_BITS'(r_elapsed)),
        .i_dur     (r_dur),
        .o_value   (lane_x)
    );

    ppmi_muldiv #(
        .COORD_BITS(CB)
    ) u_lane_y (
        .i_clk     (i_clk),
        .i_init    (i_op == OP_DIV_INIT),
        .i_step    (i_op == OP_DIV_STEP),
        .i_origin  (r_oy),
        .i_goal    (r_gy),
        .i_elapsed (DUR_BITS'(r_elapsed)),
        .i_dur     (r_dur),
        .o_value   (lane_y)
    );

    assign at_goal  = (r_px == r_gx) && (r_py == r_gy);
    assign out_busy = r_o_valid && i_out_stall;
    assign diff_t   = r_now - r_start;

    always_comb begin
        o_flags.out_busy  = out_busy;
        o_flags.at_goal   = at_goal;
        o_flags.time_mode = (r_move_mode == MM_TIME);
        o_flags.finished  = r_finished;
        o_flags.e_gt_d    = EW'(r_elapsed) > EW'(r_dur);
        o_flags.d_zero    = (r_dur == '0);
        o_flags.cmd       = r_cmd;
    end

    always_comb begin
        n_px       = r_px;
        n_py       = r_py;
        n_gx       = r_gx;
        n_gy       = r_gy;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_start    = r_start;
        n_sleep    = r_sleep;
        n_finished = r_finished;
        n_elapsed  = r_elapsed;
        n_arrived  = r_arrived;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_px     = r_o_px;
        n_o_py     = r_o_py;
        n_o_at     = r_o_at;
        n_o_arr    = r_o_arr;
        case (i_op)
            OP_LATCH: begin
                n_arrived = 1'b0;
            end
            OP_SPEED: begin
                n_px = speed_axis(r_px, r_gx, r_speed_x);
                n_py = speed_axis(r_py, r_gy, r_speed_y);
            end
            OP_ARRIVE: begin
                n_arrived = at_goal;
            end
            OP_ELAPSED: begin
                n_elapsed = diff_t[TB-1] ? '0 : diff_t;
            end
            OP_DIV_DONE: begin
                n_px = lane_x;
                n_py = lane_y;
            end
            OP_SNAP: begin
                n_px       = r_gx;
                n_py       = r_gy;
                n_finished = 1'b1;
            end
            OP_ORIGIN: begin
                n_px = r_ox;
                n_py = r_oy;
            end
            OP_SET_TARGET: begin
                n_gx       = r_cx;
                n_gy       = r_cy;
                n_ox       = r_px;
                n_oy       = r_py;
                n_start    = r_now;
                n_finished = 1'b0;
            end
            OP_PAUSE: begin
                n_sleep = r_now;
            end
            OP_RESUME: begin
                if (!r_finished && (r_sleep != '0)) begin
                    n_start = r_start + r_now - r_sleep;
                end
            end
            OP_STOP: begin
                n_gx = r_px;
                n_gy = r_py;
            end
            OP_PLACE: begin
                n_px = r_cx;
                n_py = r_cy;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    n_o_valid = 1'b1;
                    n_o_px    = IO_COORD_BITS'(r_px);
                    n_o_py    = IO_COORD_BITS'(r_py);
                    n_o_at    = at_goal;
                    n_o_arr   = r_arrived;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_mode <= MM_TIME;
            r_speed_x   <= SPEED_RESET;
            r_speed_y   <= SPEED_RESET;
            r_dur       <= DUR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOVE_MODE: r_move_mode <= i_cfg_data[0];
                CFG_SPEED_X:   r_speed_x   <= i_cfg_data[SPEED_BITS-1:0];
                CFG_SPEED_Y:   r_speed_y   <= i_cfg_data[SPEED_BITS-1:0];
                CFG_DURATION:  r_dur       <= i_cfg_data[DUR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_op == OP_LATCH) && i_accept) begin
            r_cmd <= t_cmd'(i_mode);
            r_now <= TB'(i_now_ms);
            r_cx  <= CB'(i_coord_x);
            r_cy  <= CB'(i_coord_y);
        end
        r_elapsed <= n_elapsed;
        r_arrived <= n_arrived;
        r_o_px    <= n_o_px;
        r_o_py    <= n_o_py;
        r_o_at    <= n_o_at;
        r_o_arr   <= n_o_arr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px       <= '0;
            r_py       <= '0;
            r_gx       <= '0;
            r_gy       <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_start    <= '0;
            r_sleep    <= '0;
            r_finished <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_px       <= n_px;
            r_py       <= n_py;
            r_gx       <= n_gx;
            r_gy       <= n_gy;
            r_ox       <= n_ox;
            r_oy       <= n_oy;
            r_start    <= n_start;
            r_sleep    <= n_sleep;
            r_finished <= n_finished;
            r_o_valid  <= n_o_valid;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_pos_x     = r_o_px;
    assign o_pos_y     = r_o_py;
    assign o_at_target = r_o_at;
    assign o_arrived   = r_o_arr;

endmodule

@@ src/ppmi_useq.sv @@
`timescale 1ns / 1ps

module ppmi_useq
    import ppmi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_flags i_flags,
    output t_op    o_op,
    output logic   o_idle
);

    localparam int CNTW = $clog2(COORD_BITS + 2);

    t_upc            r_upc, n_upc;
    logic [CNTW-1:0] r_cnt, n_cnt;

    t_uword w;
    logic   take;
    t_upc   dest;

    always_comb begin
        w    = ucode_rom(r_upc);
        dest = w.target;
        case (w.cond)
            C_ALWAYS:    take = 1'b1;
            C_OUT_BUSY:  take = i_flags.out_busy;
            C_NO_ITEM:   take = !i_accept;
            C_DISPATCH: begin
                take = 1'b1;
                dest = dispatch(i_flags.cmd);
            end
            C_AT_GOAL:   take = i_flags.at_goal;
            C_TIME_MODE: take = i_flags.time_mode;
            C_FINISHED:  take = i_flags.finished;
            C_E_GT_D:    take = i_flags.e_gt_d;
            C_D_ZERO:    take = i_flags.d_zero;
            C_LOOP:      take = (r_cnt != CNTW'(1));
            default:     take = 1'b0;
        endcase
        n_upc = take ? dest : r_upc + 1'b1;
        n_cnt = r_cnt;
        if (w.cnt_ld) begin
            n_cnt = CNTW'(COORD_BITS + 1);
        end else if (w.cnt_dec) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
            r_cnt <= '0;
        end else begin
            r_upc <= n_upc;
            r_cnt <= n_cnt;
        end
    end

    assign o_op   = w.op;
    assign o_idle = (r_upc == U_IDLE);

endmodule

@@ src/ppmi_check.sv @@
`timescale 1ns / 1ps

module ppmi_check
    import ppmi_pkg::*;
(
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic signed [IO_COORD_BITS-1:0] o_pos_x,
    input logic signed [IO_COORD_BITS-1:0] o_pos_y,
    input logic                            o_at_target,
    input logic                            o_arrived
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_at_target) && $stable(o_arrived))
        else $error("Stalled result changed.");

    a_arrived_at: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_arrived |-> o_at_target)
        else $error("Arrived reported away from the target.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Second item taken while one is in work.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Block not idle after reset.");

endmodule

bind point_to_point_motion_interpolator ppmi_check u_ppmi_check (.*);
